>>> src/pse_pkg.sv
`timescale 1ns / 1ps

package pse_pkg;

	localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_BORDER_PX    = 2'd2;

	localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
	localparam logic [16:0] ADLER_MOD  = 17'd65521;
	localparam logic [7:0]  ZLIB_CMF   = 8'd120;
	localparam logic [7:0]  ZLIB_FLG   = 8'd156;
	localparam logic [7:0]  BLK_STORED = 8'd1;
	localparam logic [7:0]  SAMPLE_BITS = 8'd8;
	localparam logic [7:0]  WHITE      = 8'd255;
	localparam logic [7:0]  FILTER_NONE = 8'd0;
	localparam logic [31:0] IHDR_LEN   = 32'd13;
	localparam logic [16:0] IDAT_EXTRA = 17'd11;

	typedef struct packed {
		logic        cmd;
		logic [7:0]  pixel;
		logic        serr;
		logic [15:0] data_len;
		logic [13:0] tot_w;
		logic [13:0] tot_h;
		logic [7:0]  lat_b;
		logic [13:0] row_end;
		logic [13:0] col_end;
	} pse_item_t;

	function automatic logic [7:0] pse_sig_byte(input logic [2:0] k);
		logic [7:0] r;
		case (k)
			3'd0: r = 8'd137;
			3'd1: r = 8'd80;
			3'd2: r = 8'd78;
			3'd3: r = 8'd71;
			3'd4: r = 8'd13;
			3'd5: r = 8'd10;
			3'd6: r = 8'd26;
			default: r = 8'd10;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] pse_iend_byte(input logic [3:0] k);
		logic [7:0] r;
		case (k)
			4'd4: r = 8'h49;
			4'd5: r = 8'h45;
			4'd6: r = 8'h4E;
			4'd7: r = 8'h44;
			4'd8: r = 8'hAE;
			4'd9: r = 8'h42;
			4'd10: r = 8'h60;
			4'd11: r = 8'h82;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] pse_ihdr_type(input logic [1:0] k);
		logic [7:0] r;
		case (k)
			2'd0: r = 8'h49;
			2'd1: r = 8'h48;
			2'd2: r = 8'h44;
			default: r = 8'h52;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] pse_idat_type(input logic [1:0] k);
		logic [7:0] r;
		case (k)
			2'd0: r = 8'h49;
			2'd1: r = 8'h44;
			2'd2: r = 8'h41;
			default: r = 8'h54;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] pse_be_byte(input logic [31:0] v, input logic [1:0] k);
		logic [7:0] r;
		case (k)
			2'd0: r = v[31:24];
			2'd1: r = v[23:16];
			2'd2: r = v[15:8];
			default: r = v[7:0];
		endcase
		return r;
	endfunction

	function automatic logic [31:0] pse_crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

endpackage

>>> src/pse_front.sv
`timescale 1ns / 1ps

module pse_front #(
	parameter int MAX_DIM = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  cmd,
	input  logic [7:0]            pixel,
	input  logic [12:0]           image_width,
	input  logic [12:0]           image_height,
	input  logic [7:0]            border_px,
	input  logic                  q_ready,
	output logic                  q_push,
	output pse_pkg::pse_item_t    q_item
);
	import pse_pkg::*;

	logic        valid_s1, valid_s2;
	pse_item_t   item_s1, item_s2, item_d, item_cls;
	logic        adv_s1, adv_s2;
	logic [12:0] lat_w, lat_h;
	logic [14:0] tot_w_p1;
	logic [28:0] prod;

	// dimensions clamp at the size limit
	assign lat_w = ({4'd0, image_width} > 17'(MAX_DIM)) ? 13'(MAX_DIM) : image_width;
	assign lat_h = ({4'd0, image_height} > 17'(MAX_DIM)) ? 13'(MAX_DIM) : image_height;

	always_comb begin
		item_d          = '0;
		item_d.cmd      = cmd;
		item_d.pixel    = pixel;
		item_d.tot_w    = {1'b0, lat_w} + {5'd0, border_px, 1'b0};
		item_d.tot_h    = {1'b0, lat_h} + {5'd0, border_px, 1'b0};
		item_d.lat_b    = border_px;
		item_d.row_end  = {1'b0, lat_h} + {6'd0, border_px};
		item_d.col_end  = {1'b0, lat_w} + {6'd0, border_px};
	end

	assign tot_w_p1 = {1'b0, item_s1.tot_w} + 15'd1;
	assign prod     = {15'd0, item_s1.tot_h} * {14'd0, tot_w_p1};

	always_comb begin
		item_cls          = item_s1;
		item_cls.serr     = |prod[28:16];
		item_cls.data_len = prod[15:0];
	end

	assign adv_s2   = !valid_s2 || q_ready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;
	assign q_push   = valid_s2 && q_ready;
	assign q_item   = item_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			item_s1 <= item_d;
		end
		if (adv_s2 && valid_s1) begin
			item_s2 <= item_cls;
		end
	end

endmodule

>>> src/pse_queue.sv
`timescale 1ns / 1ps

module pse_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  pse_pkg::pse_item_t    push_item,
	output logic                  push_ready,
	output logic                  pop_valid,
	input  logic                  pop,
	output pse_pkg::pse_item_t    pop_item
);
	import pse_pkg::*;

	localparam logic [1:0] QDEPTH = 2'd2;

	pse_item_t  mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;

	assign push_ready = (cnt_q != QDEPTH);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q != QDEPTH))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (cnt_q != 2'd0))
		else $error("queue read while empty");

endmodule

>>> src/pse_back.sv
`timescale 1ns / 1ps

module pse_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	output logic                  q_pop,
	input  pse_pkg::pse_item_t    q_item,
	output logic                  res_valid,
	input  logic                  res_ready,
	output logic                  out_valid,
	output logic [7:0]            out_byte,
	output logic                  pixel_taken,
	output logic                  last_byte,
	output logic                  size_error
);
	import pse_pkg::*;

	typedef enum logic [10:0] {
		PH_IDLE       = 11'b000_0000_0001,
		PH_SIG        = 11'b000_0000_0010,
		PH_IHDR_LEN   = 11'b000_0000_0100,
		PH_IHDR_BODY  = 11'b000_0000_1000,
		PH_IHDR_CRC   = 11'b000_0001_0000,
		PH_IDAT_LEN   = 11'b000_0010_0000,
		PH_IDAT_HEAD  = 11'b000_0100_0000,
		PH_IDAT_DATA  = 11'b000_1000_0000,
		PH_IDAT_ADLER = 11'b001_0000_0000,
		PH_IDAT_CRC   = 11'b010_0000_0000,
		PH_IEND       = 11'b100_0000_0000
	} phase_t;

	phase_t      phase_q, ph_eff, ph_n;
	logic [4:0]  byte_q, k, k_n;
	logic [13:0] row_q, col_q, row_n, col_n, row_inc;
	logic [31:0] crc_q, crc_step;
	logic [15:0] al_q, ah_q;
	logic [13:0] tot_w_q, tot_h_q, row_end_q, col_end_q;
	logic [15:0] len_q;
	logic [7:0]  lat_b_q;

	logic        take;
	logic [7:0]  b;
	logic        emit, taken, last;
	logic        crc_upd, crc_clr, adl_upd, adl_clr;
	logic [16:0] len11, al_sum, ah_sum, al_new, ah_new;

	logic        res_valid_q, out_valid_q, taken_q, last_q, serr_q;
	logic [7:0]  out_byte_q;

	assign take  = q_valid && (!res_valid_q || res_ready);
	assign q_pop = take;

	assign ph_eff = q_item.cmd ? (q_item.serr ? PH_IDLE : PH_SIG) : phase_q;
	assign k      = q_item.cmd ? 5'd0 : byte_q;
	assign len11  = {1'b0, len_q} + IDAT_EXTRA;
	assign row_inc = row_q + 14'd1;

	always_comb begin
		b       = 8'd0;
		emit    = 1'b0;
		taken   = 1'b0;
		last    = 1'b0;
		ph_n    = ph_eff;
		k_n     = k + 5'd1;
		crc_upd = 1'b0;
		crc_clr = 1'b0;
		adl_upd = 1'b0;
		adl_clr = 1'b0;
		row_n   = row_q;
		col_n   = col_q;
		case (ph_eff)
			PH_IDLE: begin
				k_n = 5'd0;
			end
			PH_SIG: begin
				emit = 1'b1;
				b    = pse_sig_byte(k[2:0]);
				if (k == 5'd7) begin
					ph_n = PH_IHDR_LEN;
					k_n  = 5'd0;
				end
			end
			PH_IHDR_LEN: begin
				emit = 1'b1;
				b    = pse_be_byte(IHDR_LEN, k[1:0]);
				if (k == 5'd3) begin
					ph_n    = PH_IHDR_BODY;
					k_n     = 5'd0;
					crc_clr = 1'b1;
				end
			end
			PH_IHDR_BODY: begin
				emit    = 1'b1;
				crc_upd = 1'b1;
				if (k < 5'd4) begin
					b = pse_ihdr_type(k[1:0]);
				end else if (k < 5'd8) begin
					b = pse_be_byte({18'd0, tot_w_q}, k[1:0]);
				end else if (k < 5'd12) begin
					b = pse_be_byte({18'd0, tot_h_q}, k[1:0]);
				end else if (k == 5'd12) begin
					b = SAMPLE_BITS;
				end
				if (k == 5'd16) begin
					ph_n = PH_IHDR_CRC;
					k_n  = 5'd0;
				end
			end
			PH_IHDR_CRC: begin
				emit = 1'b1;
				b    = pse_be_byte(~crc_q, k[1:0]);
				if (k == 5'd3) begin
					ph_n = PH_IDAT_LEN;
					k_n  = 5'd0;
				end
			end
			PH_IDAT_LEN: begin
				emit = 1'b1;
				b    = pse_be_byte({15'd0, len11}, k[1:0]);
				if (k == 5'd3) begin
					ph_n    = PH_IDAT_HEAD;
					k_n     = 5'd0;
					crc_clr = 1'b1;
					adl_clr = 1'b1;
				end
			end
			PH_IDAT_HEAD: begin
				emit    = 1'b1;
				crc_upd = 1'b1;
				if (k < 5'd4) begin
					b = pse_idat_type(k[1:0]);
				end else if (k == 5'd4) begin
					b = ZLIB_CMF;
				end else if (k == 5'd5) begin
					b = ZLIB_FLG;
				end else if (k == 5'd6) begin
					b = BLK_STORED;
				end else if (k == 5'd7) begin
					b = len_q[7:0];
				end else if (k == 5'd8) begin
					b = len_q[15:8];
				end else if (k == 5'd9) begin
					b = ~len_q[7:0];
				end else begin
					b = ~len_q[15:8];
				end
				if (k == 5'd10) begin
					ph_n  = (len_q == 16'd0) ? PH_IDAT_ADLER : PH_IDAT_DATA;
					k_n   = 5'd0;
					row_n = 14'd0;
					col_n = 14'd0;
				end
			end
			PH_IDAT_DATA: begin
				emit    = 1'b1;
				crc_upd = 1'b1;
				adl_upd = 1'b1;
				if (col_q == 14'd0) begin
					b = FILTER_NONE;
				end else if (row_q >= {6'd0, lat_b_q} && row_q < row_end_q &&
						col_q > {6'd0, lat_b_q} && col_q <= col_end_q) begin
					b     = q_item.pixel;
					taken = 1'b1;
				end else begin
					b = WHITE;
				end
				if (col_q >= tot_w_q) begin
					col_n = 14'd0;
					row_n = row_inc;
					if (row_inc >= tot_h_q) begin
						ph_n = PH_IDAT_ADLER;
						k_n  = 5'd0;
					end
				end else begin
					col_n = col_q + 14'd1;
				end
			end
			PH_IDAT_ADLER: begin
				emit    = 1'b1;
				crc_upd = 1'b1;
				b       = pse_be_byte({ah_q, al_q}, k[1:0]);
				if (k == 5'd3) begin
					ph_n = PH_IDAT_CRC;
					k_n  = 5'd0;
				end
			end
			PH_IDAT_CRC: begin
				emit = 1'b1;
				b    = pse_be_byte(~crc_q, k[1:0]);
				if (k == 5'd3) begin
					ph_n = PH_IEND;
					k_n  = 5'd0;
				end
			end
			PH_IEND: begin
				emit = 1'b1;
				b    = pse_iend_byte(k[3:0]);
				if (k >= 5'd11) begin
					ph_n = PH_IDLE;
					k_n  = 5'd0;
					last = 1'b1;
				end
			end
			default: begin
				ph_n = PH_IDLE;
				k_n  = 5'd0;
			end
		endcase
	end

	assign crc_step = pse_crc_byte(crc_q, b);
	assign al_sum   = {1'b0, al_q} + {9'd0, b};
	assign al_new   = (al_sum >= ADLER_MOD) ? (al_sum - ADLER_MOD) : al_sum;
	assign ah_sum   = {1'b0, ah_q} + {1'b0, al_new[15:0]};
	assign ah_new   = (ah_sum >= ADLER_MOD) ? (ah_sum - ADLER_MOD) : ah_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			byte_q      <= 5'd0;
			row_q       <= 14'd0;
			col_q       <= 14'd0;
			crc_q       <= CRC_INIT;
			al_q        <= 16'd1;
			ah_q        <= 16'd0;
			res_valid_q <= 1'b0;
		end else begin
			if (take) begin
				phase_q <= ph_n;
				byte_q  <= k_n;
				row_q   <= row_n;
				col_q   <= col_n;
				if (crc_clr) begin
					crc_q <= CRC_INIT;
				end else if (crc_upd) begin
					crc_q <= crc_step;
				end
				if (adl_clr) begin
					al_q <= 16'd1;
					ah_q <= 16'd0;
				end else if (adl_upd) begin
					al_q <= al_new[15:0];
					ah_q <= ah_new[15:0];
				end
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && q_item.cmd) begin
			tot_w_q   <= q_item.tot_w;
			tot_h_q   <= q_item.tot_h;
			len_q     <= q_item.data_len;
			lat_b_q   <= q_item.lat_b;
			row_end_q <= q_item.row_end;
			col_end_q <= q_item.col_end;
		end
		if (take) begin
			out_valid_q <= emit;
			out_byte_q  <= b;
			taken_q     <= taken;
			last_q      <= last;
			serr_q      <= q_item.cmd && q_item.serr;
		end
	end

	assign res_valid   = res_valid_q;
	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign pixel_taken = taken_q;
	assign last_byte   = last_q;
	assign size_error  = serr_q;

	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !q_item.cmd && phase_q == PH_IDLE) |=> (res_valid && !out_valid))
		else $error("byte emitted while idle");

	a_oversize: assert property (@(posedge clk) disable iff (!arst_n)
		(take && q_item.cmd && q_item.serr) |=> (size_error && !out_valid && phase_q == PH_IDLE))
		else $error("oversized start not rejected");

	a_iend_last: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !q_item.cmd && phase_q == PH_IEND && byte_q == 5'd11)
		|=> (last_byte && out_valid && phase_q == PH_IDLE))
		else $error("file end not flagged");

endmodule

>>> src/png_stored_image_encoder_unit.sv
`timescale 1ns / 1ps

// channel  | handshake            | payload
// ---------+----------------------+-------------------------------------------------
// input    | in_valid / in_ready  | cmd, pixel
// result   | res_valid / res_ready| out_valid, out_byte, pixel_taken, last_byte,
//          |                      | size_error
// config   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one beat per cycle sustained while res_ready stays high; a result is registered
// in turn by the two front stages, the queue and the byte sequencer.
// the rate is set by the byte-wise crc-32 and adler-32 update in the sequencer.
// reset clears the sequencer to idle; no clearing pass, config ready at once.
// a stalled result holds its register; the queue and front stages absorb four beats.

module png_stored_image_encoder_unit #(
	parameter int MAX_DIM = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [7:0]  pixel,
	output logic        res_valid,
	input  logic        res_ready,
	output logic        out_valid,
	output logic [7:0]  out_byte,
	output logic        pixel_taken,
	output logic        last_byte,
	output logic        size_error,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data
);
	import pse_pkg::*;

	logic [12:0] width_q, height_q;
	logic [7:0]  border_q;
	logic        q_push, q_ready, q_valid, q_pop;
	pse_item_t   push_item, pop_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 13'd1;
			height_q <= 13'd1;
			border_q <= 8'd0;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_IMAGE_WIDTH) begin
				width_q <= cfg_data;
			end
			if (cfg_index == CFG_IMAGE_HEIGHT) begin
				height_q <= cfg_data;
			end
			if (cfg_index == CFG_BORDER_PX) begin
				border_q <= cfg_data[7:0];
			end
		end
	end

	pse_front #(
		.MAX_DIM(MAX_DIM)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.pixel       (pixel),
		.image_width (width_q),
		.image_height(height_q),
		.border_px   (border_q),
		.q_ready     (q_ready),
		.q_push      (q_push),
		.q_item      (push_item)
	);

	pse_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.push_ready(q_ready),
		.pop_valid (q_valid),
		.pop       (q_pop),
		.pop_item  (pop_item)
	);

	pse_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_pop      (q_pop),
		.q_item     (pop_item),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.out_valid  (out_valid),
		.out_byte   (out_byte),
		.pixel_taken(pixel_taken),
		.last_byte  (last_byte),
		.size_error (size_error)
	);

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import pse_pkg::*;

	localparam int LIMIT = 1000000;
	localparam int IMG_MAX_DIM = 4096;

	typedef enum int {
		ST_IDLE, ST_SIG, ST_IHDR_LEN, ST_IHDR_BODY, ST_IHDR_CRC, ST_IDAT_LEN,
		ST_IDAT_HEAD, ST_IDAT_DATA, ST_IDAT_ADLER, ST_IDAT_CRC, ST_IEND
	} enc_state_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic       taken;
		logic       last;
		logic       serr;
	} file_beat_t;

	class png_scoreboard;
		localparam bit [63:0] PNG_SIG   = 64'h89504E470D0A1A0A;
		localparam bit [95:0] IEND_TAIL = 96'h00000000_49454E44_AE426082;
		localparam bit [31:0] IHDR_TAG  = 32'h49484452;
		localparam bit [31:0] IDAT_TAG  = 32'h49444154;

		bit [12:0]   reg_w = 13'd1;
		bit [12:0]   reg_h = 13'd1;
		bit [7:0]    reg_b = 8'd0;
		enc_state_t  st = ST_IDLE;
		int unsigned idx, row, col;
		int unsigned lat_w, lat_h, lat_b, tot_w, tot_h;
		bit [31:0]   dlen;
		bit [31:0]   crc = CRC_INIT;
		int unsigned adl_lo = 1, adl_hi = 0;
		file_beat_t  expq[$];
		int          errors;

		function void write_reg(bit [1:0] index, bit [12:0] value);
			case (index)
				CFG_IMAGE_WIDTH: reg_w = value;
				CFG_IMAGE_HEIGHT: reg_h = value;
				CFG_BORDER_PX: reg_b = value[7:0];
				default: ;
			endcase
		endfunction

		// bytes of the stored block for the registers as they stand now
		function longint data_bytes();
			int unsigned w, h;
			w = reg_w > IMG_MAX_DIM ? IMG_MAX_DIM : int'(reg_w);
			h = reg_h > IMG_MAX_DIM ? IMG_MAX_DIM : int'(reg_h);
			return longint'(h + 2 * reg_b) * longint'(w + 2 * reg_b + 1);
		endfunction

		function void enter(enc_state_t s);
			st = s;
			idx = 0;
		endfunction

		function bit [7:0] be_of(bit [31:0] v, int unsigned k);
			return v[8 * (3 - k % 4) +: 8];
		endfunction

		function bit [31:0] crc_add(bit [31:0] c, bit [7:0] b);
			bit [31:0] r;
			r = c ^ {24'd0, b};
			for (int i = 0; i < 8; i++)
				r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
			return r;
		endfunction

		function void adler_add(bit [7:0] b);
			adl_lo = adl_lo + b;
			if (adl_lo >= 32'(ADLER_MOD))
				adl_lo = adl_lo - 32'(ADLER_MOD);
			adl_hi = adl_hi + adl_lo;
			if (adl_hi >= 32'(ADLER_MOD))
				adl_hi = adl_hi - 32'(ADLER_MOD);
		endfunction

		function bit [7:0] next_file_byte(bit [7:0] pix, output bit taken, output bit last);
			bit [7:0]    b;
			int unsigned k;
			int unsigned x;
			b = 8'd0;
			taken = 1'b0;
			last = 1'b0;
			k = idx;
			idx++;
			case (st)
				ST_SIG: begin
					b = PNG_SIG[63 - 8 * k -: 8];
					if (idx == 8)
						enter(ST_IHDR_LEN);
				end
				ST_IHDR_LEN: begin
					b = be_of(IHDR_LEN, k);
					if (idx == 4) begin
						enter(ST_IHDR_BODY);
						crc = CRC_INIT;
					end
				end
				ST_IHDR_BODY: begin
					if (k < 4)
						b = IHDR_TAG[31 - 8 * k -: 8];
					else if (k < 8)
						b = be_of(32'(tot_w), k - 4);
					else if (k < 12)
						b = be_of(32'(tot_h), k - 8);
					else if (k == 12)
						b = SAMPLE_BITS;
					else
						b = 8'd0;
					crc = crc_add(crc, b);
					if (idx == 17)
						enter(ST_IHDR_CRC);
				end
				ST_IHDR_CRC: begin
					b = be_of(~crc, k);
					if (idx == 4)
						enter(ST_IDAT_LEN);
				end
				ST_IDAT_LEN: begin
					b = be_of(dlen + 32'(IDAT_EXTRA), k);
					if (idx == 4) begin
						enter(ST_IDAT_HEAD);
						crc = CRC_INIT;
						adl_lo = 1;
						adl_hi = 0;
					end
				end
				ST_IDAT_HEAD: begin
					if (k < 4)
						b = IDAT_TAG[31 - 8 * k -: 8];
					else if (k == 4)
						b = ZLIB_CMF;
					else if (k == 5)
						b = ZLIB_FLG;
					else if (k == 6)
						b = BLK_STORED;
					else if (k == 7)
						b = dlen[7:0];
					else if (k == 8)
						b = dlen[15:8];
					else if (k == 9)
						b = ~dlen[7:0];
					else
						b = ~dlen[15:8];
					crc = crc_add(crc, b);
					if (idx == 11) begin
						enter(dlen == 0 ? ST_IDAT_ADLER : ST_IDAT_DATA);
						row = 0;
						col = 0;
					end
				end
				ST_IDAT_DATA: begin
					if (col == 0) begin
						b = FILTER_NONE;
					end else begin
						x = col - 1;
						if (row >= lat_b && row < lat_b + lat_h &&
						    x >= lat_b && x < lat_b + lat_w) begin
							b = pix;
							taken = 1'b1;
						end else begin
							b = WHITE;
						end
					end
					crc = crc_add(crc, b);
					adler_add(b);
					col++;
					if (col > tot_w) begin
						col = 0;
						row++;
						if (row >= tot_h)
							enter(ST_IDAT_ADLER);
					end
				end
				ST_IDAT_ADLER: begin
					b = be_of({adl_hi[15:0], adl_lo[15:0]}, k);
					crc = crc_add(crc, b);
					if (idx == 4)
						enter(ST_IDAT_CRC);
				end
				ST_IDAT_CRC: begin
					b = be_of(~crc, k);
					if (idx == 4)
						enter(ST_IEND);
				end
				ST_IEND: begin
					b = IEND_TAIL[95 - 8 * (k < 12 ? k : 11) -: 8];
					if (idx >= 12) begin
						enter(ST_IDLE);
						last = 1'b1;
					end
				end
				default: enter(ST_IDLE);
			endcase
			return b;
		endfunction

		function void note_input(bit c, bit [7:0] pix);
			file_beat_t e;
			longint     len;
			bit         t, l;
			e = '0;
			if (c) begin
				lat_w = reg_w > IMG_MAX_DIM ? IMG_MAX_DIM : int'(reg_w);
				lat_h = reg_h > IMG_MAX_DIM ? IMG_MAX_DIM : int'(reg_h);
				lat_b = reg_b;
				tot_w = lat_w + 2 * lat_b;
				tot_h = lat_h + 2 * lat_b;
				len = data_bytes();
				if (len > 65535) begin
					e.serr = 1'b1;
					dlen = 0;
					enter(ST_IDLE);
				end else begin
					dlen = 32'(len);
					enter(ST_SIG);
				end
			end
			if (st != ST_IDLE) begin
				e.valid = 1'b1;
				e.data = next_file_byte(pix, t, l);
				e.taken = t;
				e.last = l;
			end
			expq.push_back(e);
		endfunction

		function void cmp_field(string what, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$display("%0t %s mismatch: expected %0h actual %0h", $time, what, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic v, logic [7:0] b, logic t, logic l, logic s);
			file_beat_t e;
			if (expq.size() == 0) begin
				$display("%0t unexpected result beat: expected none actual byte %0h", $time, b);
				errors++;
				return;
			end
			e = expq.pop_front();
			cmp_field("out_valid", 8'(e.valid), 8'(v));
			cmp_field("out_byte", e.data, b);
			cmp_field("pixel_taken", 8'(e.taken), 8'(t));
			cmp_field("last_byte", 8'(e.last), 8'(l));
			cmp_field("size_error", 8'(e.serr), 8'(s));
		endfunction

		function int pending();
			return expq.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        cmd;
	logic [7:0]  pixel;
	logic        res_valid;
	logic        res_ready;
	logic        out_valid;
	logic [7:0]  out_byte;
	logic        pixel_taken;
	logic        last_byte;
	logic        size_error;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [12:0] cfg_data;

	png_scoreboard sb = new();
	bit            idle_on;
	int unsigned   file_beats_sent;
	int unsigned   rx_beats, stall_left, hold_left, cycles;
	bit            held;

	png_stored_image_encoder_unit #(.MAX_DIM(IMG_MAX_DIM)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.pixel(pixel),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.out_valid(out_valid),
		.out_byte(out_byte),
		.pixel_taken(pixel_taken),
		.last_byte(last_byte),
		.size_error(size_error),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// result side: random stalls, one long hold so the input backs up
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			sb.check_result(out_valid, out_byte, pixel_taken, last_byte, size_error);
			rx_beats++;
		end
		if (hold_left != 0) begin
			hold_left--;
			res_ready <= 1'b0;
		end else if (!held && rx_beats >= 150) begin
			held = 1'b1;
			hold_left = 79;
			res_ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left--;
			res_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 14) - 1;
			res_ready <= 1'b0;
		end else begin
			res_ready <= 1'b1;
		end
	end

	task automatic push_beat(input bit c, input bit [7:0] pix);
		int gap;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 14);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		pixel <= pix;
		do @(posedge clk); while (!in_ready);
		sb.note_input(c, pix);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] index, input logic [12:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(index, value);
	endtask

	task automatic load_image_regs(input bit [12:0] w, input bit [12:0] h, input bit [7:0] b);
		wait_idle();
		write_reg(CFG_IMAGE_WIDTH, w);
		write_reg(CFG_IMAGE_HEIGHT, h);
		write_reg(CFG_BORDER_PX, {5'd0, b});
		cfg_valid <= 1'b0;
	endtask

	// one start beat, then pull the whole file or cut it short for a restart
	task automatic run_file(input bit may_abort);
		longint      dbytes;
		int unsigned span;
		dbytes = sb.data_bytes();
		push_beat(1'b1, 8'($urandom()));
		file_beats_sent++;
		if (dbytes > 65535)
			return;
		span = 68 + int'(dbytes);
		if (may_abort && $urandom_range(0, 4) == 0)
			span = $urandom_range(2, span - 1);
		repeat (span - 1) push_beat(1'b0, 8'($urandom()));
		file_beats_sent += span - 1;
		repeat ($urandom_range(0, 2)) push_beat(1'b0, 8'($urandom()));
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		cmd <= 1'b0;
		pixel <= 8'd0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_IMAGE_WIDTH;
		cfg_data <= 13'd0;
		idle_on = 1'b1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle before any start, then a file at the power-on size
		push_beat(1'b0, 8'h00);
		push_beat(1'b0, 8'hFF);
		run_file(1'b0);
		// restart while a file is in flight
		push_beat(1'b1, 8'hFF);
		repeat (6) push_beat(1'b0, 8'h00);
		run_file(1'b0);
		// saturated and oversized dimensions
		load_image_regs(13'd8191, 13'd8191, 8'd255);
		run_file(1'b0);
		push_beat(1'b0, 8'hA5);
		load_image_regs(13'd255, 13'd256, 8'd0);
		run_file(1'b0);
		// zero width or height
		load_image_regs(13'd0, 13'd0, 8'd0);
		run_file(1'b0);
		load_image_regs(13'd0, 13'd3, 8'd2);
		run_file(1'b0);
		load_image_regs(13'd5, 13'd0, 8'd1);
		run_file(1'b0);

		while (file_beats_sent < 450) begin
			if ($urandom_range(0, 9) == 0)
				load_image_regs(13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)),
					8'($urandom_range(200, 255)));
			else
				load_image_regs(13'($urandom_range(0, 10)), 13'($urandom_range(0, 6)),
					8'($urandom_range(0, 2)));
			repeat ($urandom_range(1, 2)) run_file(1'b1);
		end

		// saturated width with no rows, then a bordered file, without random gaps or stalls
		idle_on = 1'b0;
		load_image_regs(13'd8191, 13'd0, 8'd0);
		run_file(1'b0);
		load_image_regs(13'd3, 13'd2, 8'd1);
		run_file(1'b0);

		wait_idle();
		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

>>> png_stored_image_encoder_unit.f
src/pse_pkg.sv
src/pse_front.sv
src/pse_queue.sv
src/pse_back.sv
src/png_stored_image_encoder_unit.sv
tb/tb.sv
